@@ design/pif_pkg.sv @@
package pif_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN_LEAD,
		ST_PAD,
		ST_SIGN_TRAIL,
		ST_DIGIT
	} pif_state_t;

	localparam logic [1:0] OP_SDEC = 2'd0;
	localparam logic [1:0] OP_UDEC = 2'd1;
	localparam logic [1:0] OP_HEXL = 2'd2;
	localparam logic [1:0] OP_HEXU = 2'd3;

	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_UPPER = 7'h41;
	localparam logic [6:0] CH_LOWER = 7'h61;

	localparam int DIGIT_SLOTS = 16;

	// reciprocal of ten, exact for every 32-bit dividend with a shift of 35
	localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam int RECIP_SHIFT = 35;

endpackage

@@ design/padded_integer_formatter.sv @@
// After a start, the digits (1 to 10) are extracted one per cycle, then the
// characters leave one per cycle; strobe, out_char and last are registered from the output phase.
// A new word is taken only once the last one has been issued, as start is ignored while busy;
// the pace is set by the single shared divider (by ten, or sixteen for hex) and the idle state between words.
// busy is high from the accepting edge until the last character has been issued.
// Reset (arst_n low) returns the sequencer to idle and clears strobe; no fill pass.
module padded_integer_formatter
	import pif_pkg::*;
#(
	parameter int MAX_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] number,
	input  logic [1:0]  opcode,
	input  logic        zero_fill,
	input  logic [5:0]  field_width,
	output logic        strobe,
	output logic [6:0]  out_char,
	output logic        last
);

	localparam int PW = $clog2(MAX_WIDTH + 1);
	localparam int CW = (PW > 6) ? PW : 6;

	pif_state_t state_q, state_nxt;

	logic [31:0] value_q;
	logic        neg_q;
	logic        zero_q;
	logic        hex_q;
	logic        upper_q;
	logic [PW-1:0] width_q;
	logic [PW-1:0] pad_q;
	logic [3:0]  ndig_q;
	logic [3:0]  digit_q [DIGIT_SLOTS];

	logic [31:0] div_quot;
	logic [3:0]  div_digit;
	logic        conv_done;
	logic [PW-1:0] len_calc;
	logic [PW-1:0] pad_calc;
	logic [CW-1:0] width_ext;
	logic [PW-1:0] width_sat;
	logic        accept;

	logic        emit_valid;
	logic [6:0]  emit_char;
	logic        emit_last;
	logic [3:0]  cur_digit;
	logic [6:0]  alpha;

	pif_divu u_divu (
		.value (value_q),
		.hex   (hex_q),
		.quot  (div_quot),
		.digit (div_digit)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		width_ext = CW'(field_width);
		if (width_ext > CW'(MAX_WIDTH)) begin
			width_sat = PW'(MAX_WIDTH);
		end else begin
			width_sat = PW'(field_width);
		end
	end

	// text length once this digit is in: digits so far, this one, and the sign
	always_comb begin
		conv_done = (div_quot == 32'd0);
		len_calc  = PW'(ndig_q) + PW'(1) + PW'(neg_q);
		pad_calc  = (width_q > len_calc) ? (width_q - len_calc) : '0;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = ST_CONV;
			end
			ST_CONV: begin
				if (conv_done) begin
					if (neg_q && zero_q)       state_nxt = ST_SIGN_LEAD;
					else if (pad_calc != '0)   state_nxt = ST_PAD;
					else if (neg_q)            state_nxt = ST_SIGN_TRAIL;
					else                       state_nxt = ST_DIGIT;
				end
			end
			ST_SIGN_LEAD: begin
				state_nxt = (pad_q != '0) ? ST_PAD : ST_DIGIT;
			end
			ST_PAD: begin
				if (pad_q == PW'(1)) begin
					state_nxt = (neg_q && !zero_q) ? ST_SIGN_TRAIL : ST_DIGIT;
				end
			end
			ST_SIGN_TRAIL: begin
				state_nxt = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (ndig_q == 4'd1) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cur_digit  = digit_q[ndig_q - 4'd1];
		alpha      = upper_q ? CH_UPPER : CH_LOWER;
		emit_valid = 1'b0;
		emit_char  = CH_SPACE;
		emit_last  = 1'b0;
		case (state_q)
			ST_SIGN_LEAD, ST_SIGN_TRAIL: begin
				emit_valid = 1'b1;
				emit_char  = CH_MINUS;
			end
			ST_PAD: begin
				emit_valid = 1'b1;
				emit_char  = zero_q ? CH_ZERO : CH_SPACE;
			end
			ST_DIGIT: begin
				emit_valid = 1'b1;
				emit_last  = (ndig_q == 4'd1);
				if (cur_digit < 4'd10) emit_char = CH_ZERO + 7'(cur_digit);
				else                   emit_char = alpha + 7'(cur_digit - 4'd10);
			end
			default: begin
				emit_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strobe  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			strobe  <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_char <= emit_char;
		last     <= emit_last;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					neg_q   <= (opcode == OP_SDEC) && number[31];
					value_q <= ((opcode == OP_SDEC) && number[31]) ? (32'd0 - number)
					                                                : number;
					zero_q  <= zero_fill;
					hex_q   <= (opcode == OP_HEXL) || (opcode == OP_HEXU);
					upper_q <= (opcode == OP_HEXU);
					width_q <= width_sat;
					ndig_q  <= 4'd0;
				end
			end
			ST_CONV: begin
				digit_q[ndig_q] <= div_digit;
				value_q         <= div_quot;
				ndig_q          <= ndig_q + 4'd1;
				pad_q           <= pad_calc;
			end
			ST_PAD: begin
				pad_q <= pad_q - PW'(1);
			end
			ST_DIGIT: begin
				ndig_q <= ndig_q - 4'd1;
			end
			default: begin
				pad_q <= pad_q;
			end
		endcase
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after start");

	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last && strobe |-> $past(busy))
		else $error("final character issued without a word in flight");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q != ST_IDLE) && $past(state_q != ST_CONV))
		else $error("character strobe outside an output phase");

	a_digits_present: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGIT) |-> (ndig_q != 4'd0))
		else $error("digit phase with no digits stored");

endmodule

@@ design/pif_divu.sv @@
module pif_divu
	import pif_pkg::*;
(
	input  logic [31:0] value,
	input  logic        hex,
	output logic [31:0] quot,
	output logic [3:0]  digit
);

	logic [63:0] prod;
	logic [31:0] q_dec;
	logic [31:0] q_ten;
	logic [31:0] r_dec;

	always_comb begin
		prod  = 64'(value) * 64'(RECIP_TEN);
		q_dec = 32'(prod >> RECIP_SHIFT);
		q_ten = (q_dec << 3) + (q_dec << 1);
		r_dec = value - q_ten;
		if (hex) begin
			quot  = value >> 4;
			digit = value[3:0];
		end else begin
			quot  = q_dec;
			digit = r_dec[3:0];
		end
	end

endmodule
